>>> hdl/setc_pkg.sv
`timescale 1ns / 1ps

package setc_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned SqW     = 2 * CoordW + 1;
  localparam int unsigned SumW    = 2 * CoordW + 2;
  localparam int unsigned RootN   = SumW / 2;
  localparam int unsigned LenW    = 26;
  localparam int unsigned KsW     = 32;
  localparam int unsigned ThrW    = 47;
  localparam int unsigned WfW     = 16;
  localparam int unsigned TenW    = 48;
  localparam int unsigned ProdW   = KsW + LenW;
  localparam int unsigned ThrWfW  = ThrW + WfW;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [KsW-1:0] KsReset  = 32'd65536;
  localparam logic [ThrW-1:0] ThrReset = 47'h7FFF_FFFF_FFFF;
  localparam logic [WfW-1:0] WfReset  = 16'd256;

  localparam logic [TenW:0] TenPosMax = 49'h0_7FFF_FFFF_FFFF;
  localparam logic [TenW:0] TenNegMag = 49'h0_8000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPRING = 2'd0,
    CFG_THRESH = 2'd1,
    CFG_WEAK   = 2'd2
  } cfg_reg_e;

endpackage

>>> hdl/spring_edge_tension_tear_check.sv
`timescale 1ns / 1ps

// channel | signals                                   | direction
// in      | in_valid_i, in_stall_o, begin/end, rest   | edge word in
// out     | out_valid_o, out_stall_i, length, tension | result word out
// cfg     | cfg_we_i, cfg_index_i, cfg_data_i         | register write
//
// Stages: diff, square, sum, 25 square-root bit stages (one
// root bit per stage), magnitude, ks multiply, saturate/compare.
// One word per cycle sustained. Whole pipe advances together; it holds
// only while the output word is valid and stalled.
// Reset clears valid bits and loads register defaults.

module spring_edge_tension_tear_check (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [setc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [setc_pkg::ThrW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [setc_pkg::CoordW-1:0]  begin_x_i,
  input  logic signed [setc_pkg::CoordW-1:0]  begin_y_i,
  input  logic signed [setc_pkg::CoordW-1:0]  begin_z_i,
  input  logic signed [setc_pkg::CoordW-1:0]  end_x_i,
  input  logic signed [setc_pkg::CoordW-1:0]  end_y_i,
  input  logic signed [setc_pkg::CoordW-1:0]  end_z_i,
  input  logic [setc_pkg::LenW-1:0]           rest_length_i,
  input  logic                                weak_edge_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [setc_pkg::LenW-1:0]           edge_length_o,
  output logic signed [setc_pkg::TenW-1:0]    edge_tension_o,
  output logic                                stretched_o,
  output logic                                tears_o
);

  localparam int unsigned RN = setc_pkg::RootN;

  logic [setc_pkg::KsW-1:0]    ks_q;
  logic [setc_pkg::ThrW-1:0]   thr_q;
  logic [setc_pkg::WfW-1:0]    wf_q;
  logic [setc_pkg::ThrWfW-1:0] thrwf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q  <= setc_pkg::KsReset;
      thr_q <= setc_pkg::ThrReset;
      wf_q  <= setc_pkg::WfReset;
    end else if (cfg_we_i) begin
      unique case (setc_pkg::cfg_reg_e'(cfg_index_i))
        setc_pkg::CFG_SPRING: ks_q  <= cfg_data_i[setc_pkg::KsW-1:0];
        setc_pkg::CFG_THRESH: thr_q <= cfg_data_i;
        setc_pkg::CFG_WEAK:   wf_q  <= cfg_data_i[setc_pkg::WfW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    thrwf_q <= setc_pkg::ThrWfW'(thr_q) * setc_pkg::ThrWfW'(wf_q);
  end

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // stage 1: differences
  logic                                v1_q;
  logic signed [setc_pkg::DiffW-1:0]   dx_q, dy_q, dz_q;
  logic [setc_pkg::LenW-1:0]           rest1_q;
  logic                                weak1_q;

  // stage 2: squares
  logic                                v2_q;
  logic [setc_pkg::SqW-1:0]            sx_q, sy_q, sz_q;
  logic [setc_pkg::LenW-1:0]           rest2_q;
  logic                                weak2_q;

  logic [setc_pkg::DiffW-1:0] ax, ay, az;
  assign ax = dx_q[setc_pkg::DiffW-1] ? setc_pkg::DiffW'(-dx_q) : dx_q;
  assign ay = dy_q[setc_pkg::DiffW-1] ? setc_pkg::DiffW'(-dy_q) : dy_q;
  assign az = dz_q[setc_pkg::DiffW-1] ? setc_pkg::DiffW'(-dz_q) : dz_q;

  // square-root pipe; index 0 holds the sum
  logic                       s_v_q    [0:RN];
  logic [setc_pkg::SumW-1:0]  s_x_q    [0:RN];
  logic [setc_pkg::SumW-1:0]  s_r_q    [0:RN];
  logic [setc_pkg::LenW-1:0]  s_rest_q [0:RN];
  logic                       s_weak_q [0:RN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      s_v_q[0]  <= 1'b0;
    end else if (adv) begin
      v1_q      <= in_valid_i;
      v2_q      <= v1_q;
      s_v_q[0]  <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q        <= setc_pkg::DiffW'(end_x_i) - setc_pkg::DiffW'(begin_x_i);
      dy_q        <= setc_pkg::DiffW'(end_y_i) - setc_pkg::DiffW'(begin_y_i);
      dz_q        <= setc_pkg::DiffW'(end_z_i) - setc_pkg::DiffW'(begin_z_i);
      rest1_q     <= rest_length_i;
      weak1_q     <= weak_edge_i;
      sx_q        <= setc_pkg::SqW'(ax * ax);
      sy_q        <= setc_pkg::SqW'(ay * ay);
      sz_q        <= setc_pkg::SqW'(az * az);
      rest2_q     <= rest1_q;
      weak2_q     <= weak1_q;
      s_x_q[0]    <= setc_pkg::SumW'(sx_q) + setc_pkg::SumW'(sy_q)
                   + setc_pkg::SumW'(sz_q);
      s_r_q[0]    <= '0;
      s_rest_q[0] <= rest2_q;
      s_weak_q[0] <= weak2_q;
    end
  end

  for (genvar k = 0; k < RN; k++) begin : g_root
    localparam logic [setc_pkg::SumW-1:0] Bit =
      setc_pkg::SumW'(1) << (2 * (RN - 1 - k));
    logic [setc_pkg::SumW-1:0] trial;
    logic                      take;
    assign trial = s_r_q[k] + Bit;
    assign take  = s_x_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        s_v_q[k+1] <= s_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_x_q[k+1]    <= take ? (s_x_q[k] - trial) : s_x_q[k];
        s_r_q[k+1]    <= take ? ((s_r_q[k] >> 1) + Bit) : (s_r_q[k] >> 1);
        s_rest_q[k+1] <= s_rest_q[k];
        s_weak_q[k+1] <= s_weak_q[k];
      end
    end
  end

  // magnitude of length - rest
  logic [setc_pkg::LenW-1:0] len_w;
  assign len_w = s_r_q[RN][setc_pkg::LenW-1:0];

  logic                      t1_v_q, t1_neg_q, t1_weak_q, t1_str_q;
  logic [setc_pkg::LenW-1:0] t1_len_q, t1_mag_q;

  logic                       t2_v_q, t2_neg_q, t2_weak_q, t2_str_q;
  logic [setc_pkg::LenW-1:0]  t2_len_q;
  logic [setc_pkg::ProdW-1:0] t2_prod_q;

  logic [setc_pkg::TenW:0]    qw, qneg, qpos;
  logic [setc_pkg::ThrWfW-1:0] qsh;
  logic                        tear_w;
  assign qw   = (setc_pkg::TenW+1)'(t2_prod_q[setc_pkg::ProdW-1:16]);
  assign qneg = (qw > setc_pkg::TenNegMag) ? setc_pkg::TenNegMag : qw;
  assign qpos = (qw > setc_pkg::TenPosMax) ? setc_pkg::TenPosMax : qw;
  assign qsh  = setc_pkg::ThrWfW'(qpos) << 8;
  assign tear_w = !t2_neg_q &&
                  (t2_weak_q ? (qsh > thrwf_q)
                             : (qpos > (setc_pkg::TenW+1)'(thr_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q      <= 1'b0;
      t2_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      t1_v_q      <= s_v_q[RN];
      t2_v_q      <= t1_v_q;
      out_valid_o <= t2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_len_q   <= len_w;
      t1_neg_q   <= len_w < s_rest_q[RN];
      t1_str_q   <= len_w > s_rest_q[RN];
      t1_mag_q   <= (len_w < s_rest_q[RN]) ? (s_rest_q[RN] - len_w)
                                           : (len_w - s_rest_q[RN]);
      t1_weak_q  <= s_weak_q[RN];
      t2_prod_q  <= setc_pkg::ProdW'(ks_q) * setc_pkg::ProdW'(t1_mag_q);
      t2_len_q   <= t1_len_q;
      t2_neg_q   <= t1_neg_q;
      t2_str_q   <= t1_str_q;
      t2_weak_q  <= t1_weak_q;
      edge_length_o  <= t2_len_q;
      edge_tension_o <= t2_neg_q ? setc_pkg::TenW'(-qneg)
                                 : qpos[setc_pkg::TenW-1:0];
      stretched_o    <= t2_str_q;
      tears_o        <= tear_w;
    end
  end

  a_tear_stretched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tears_o |-> stretched_o)
    else $error("tear without stretch");

  a_stretch_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stretched_o |-> !edge_tension_o[setc_pkg::TenW-1])
    else $error("stretched word with negative tension");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !edge_length_o[setc_pkg::LenW-1])
    else $error("length out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(t2_v_q) && $stable(s_v_q[0]))
    else $error("pipe moved while stalled");

endmodule
